### hw/rtl/itoa_pkg.sv
// itoa_pkg: shared types, codes and character constants for the integer to
// ASCII formatter. No dependencies; used by itoa_cell, itoa_seq and the top.
package itoa_pkg;

    // Radix the digit cells work in
    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT
    } t_radix;

    // What every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONV,
        CELL_SHIFT
    } t_cell_op;

    // Control broadcast from the sequencer to the chain
    typedef struct packed {
        t_cell_op op;
        t_radix   radix;
    } t_chain_ctl;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_SETUP,
        S_PFX0,
        S_PFX1,
        S_SIGN_LO,
        S_PAD,
        S_SIGN_HI,
        S_DIGITS
    } t_state;

    // Conversion kinds
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEXL = 3'd2;
    localparam logic [2:0] KIND_HEXU = 3'd3;
    localparam logic [2:0] KIND_OCT  = 3'd4;
    localparam logic [2:0] KIND_PTR  = 3'd5;

    // Characters
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_X       = 8'h78;

    // Pointer form always shows this many hex digits
    localparam int PTR_DIGITS = 8;

    // Digit value to its ASCII character
    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] base_ch;
        if (d < 4'd10) begin
            base_ch = CH_ZERO;
        end else begin
            base_ch = (upper ? CH_UPPER_A : CH_LOWER_A) - 8'd10;
        end
        return base_ch + {4'b0000, d};
    endfunction

endpackage

### hw/rtl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level. A row of DIGIT_SLOTS digit cells
// (itoa_cell) under one sequencer (itoa_seq). Depends on itoa_pkg.
//
// Formats one integer per input transfer as ASCII text, one character per
// output transfer, most significant first, tlast on the final character.
// An item goes through the accept, conversion (one value bit enters the cell
// row per cycle, shift-and-add-3 for decimal), shifting of leading zeros out
// of the top cell (at least one digit is kept), a setup state, then emission
// of each character as the receiver takes it. Input tready is high only
// between items; the last character can still wait in the output register
// while the next item converts.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS      = 32,
    parameter int MAX_FIELD_WIDTH = 32,
    parameter int DIGIT_SLOTS     = 11
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // tdata: value [VALUE_BITS-1:0], pad_width [+5:+0], pad_zero [+6], zero fill
    input  logic [((VALUE_BITS + 7 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: req_type [2:0]
    input  logic [2:0] s_axis_tuser,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    // tdata: char_out [7:0]
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready
);

    itoa_pkg::t_chain_ctl ctl;
    logic                 conv_bit;
    logic [DIGIT_SLOTS:0] carry;      // top carry is overflow, dropped
    logic [3:0]           dig [DIGIT_SLOTS+1];

    assign carry[0] = conv_bit;
    assign dig[0]   = 4'd0;

    // Row of digit cells, cell 0 least significant
    for (genvar g = 0; g < DIGIT_SLOTS; g++) begin : g_cell
        itoa_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_bit      (carry[g]),
            .i_digit_dn (dig[g]),
            .o_carry    (carry[g+1]),
            .o_digit    (dig[g+1])
        );
    end

    itoa_seq #(
        .VALUE_BITS      (VALUE_BITS),
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .DIGIT_SLOTS     (DIGIT_SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_value     (s_axis_tdata[VALUE_BITS-1:0]),
        .i_kind      (s_axis_tuser),
        .i_pad_width (s_axis_tdata[VALUE_BITS+5:VALUE_BITS]),
        .i_pad_zero  (s_axis_tdata[VALUE_BITS+6]),
        .o_ctl       (ctl),
        .o_bit       (conv_bit),
        .i_top_digit (dig[DIGIT_SLOTS]),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

### hw/rtl/itoa_cell.sv
// itoa_cell: one digit cell of the conversion chain. Shift-and-add-3 in
// decimal, plain shift in hex and octal, and a shift-up for emission.
// Depends on itoa_pkg.
module itoa_cell (
    input  logic                 i_clk,
    input  itoa_pkg::t_chain_ctl i_ctl,
    input  logic                 i_bit,       // carry from the lower cell
    input  logic [3:0]           i_digit_dn,  // digit of the lower cell
    output logic                 o_carry,     // carry to the upper cell
    output logic [3:0]           o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;
    logic [3:0] conv;

    // Conversion step: adjust (decimal only), then shift one bit in from below
    always_comb begin
        adj     = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        conv    = {r_digit[2:0], i_bit};
        o_carry = r_digit[3];
        unique case (i_ctl.radix)
            itoa_pkg::RADIX_DEC: begin
                conv    = {adj[2:0], i_bit};
                o_carry = adj[3];
            end
            itoa_pkg::RADIX_OCT: begin
                conv    = {1'b0, r_digit[1:0], i_bit};
                o_carry = r_digit[2];
            end
            default: begin
                conv    = {r_digit[2:0], i_bit};
                o_carry = r_digit[3];
            end
        endcase
    end

    // Next digit
    always_comb begin
        unique case (i_ctl.op)
            itoa_pkg::CELL_CLEAR: n_digit = 4'd0;
            itoa_pkg::CELL_CONV:  n_digit = conv;
            itoa_pkg::CELL_SHIFT: n_digit = i_digit_dn;
            default:              n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

### hw/rtl/itoa_seq.sv
// itoa_seq: sequencer of the formatter. Loads an item, drives the digit
// chain, then emits prefix, sign, padding and digits through an output
// register. Depends on itoa_pkg.
module itoa_seq #(
    parameter int VALUE_BITS      = 32,
    parameter int MAX_FIELD_WIDTH = 32,
    parameter int DIGIT_SLOTS     = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item in
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [2:0]            i_kind,
    input  logic [5:0]            i_pad_width,
    input  logic                  i_pad_zero,
    // chain
    output itoa_pkg::t_chain_ctl  o_ctl,
    output logic                  o_bit,
    input  logic [3:0]            i_top_digit,
    // characters out
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_char,
    output logic                  o_last
);

    localparam int BW = $clog2(VALUE_BITS);
    localparam int WW = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int CW = (WW > 6) ? WW : 6;
    localparam int LW = CW + 1;
    localparam int DW = $clog2(DIGIT_SLOTS + 1);

    itoa_pkg::t_state r_state, n_state;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [BW-1:0]         r_bit, n_bit;
    logic [DW-1:0]         r_dcnt, n_dcnt;
    logic [CW-1:0]         r_width, n_width;
    logic [CW-1:0]         r_pad, n_pad;
    itoa_pkg::t_radix      r_radix, n_radix;
    logic                  r_upper, n_upper;
    logic                  r_prefix, n_prefix;
    logic                  r_sign, n_sign;
    logic                  r_zero, n_zero;
    logic                  r_o_valid, n_o_valid;
    logic [7:0]            r_o_char, n_o_char;
    logic                  r_o_last, n_o_last;

    logic                  adv;
    logic [CW-1:0]         w_in;
    logic [LW-1:0]         len;
    logic [CW-1:0]         pad_amt;
    itoa_pkg::t_cell_op    cell_op;

    // State and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= itoa_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_val    <= n_val;
        r_bit    <= n_bit;
        r_dcnt   <= n_dcnt;
        r_width  <= n_width;
        r_pad    <= n_pad;
        r_radix  <= n_radix;
        r_upper  <= n_upper;
        r_prefix <= n_prefix;
        r_sign   <= n_sign;
        r_zero   <= n_zero;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    // Padding still owed once the digit count is known
    always_comb begin
        len     = LW'(r_dcnt) + LW'(r_sign);
        pad_amt = (LW'(r_width) > len) ? CW'(LW'(r_width) - len) : '0;
        w_in    = CW'(i_pad_width);
    end

    // Next state, chain control and character output
    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_bit     = r_bit;
        n_dcnt    = r_dcnt;
        n_width   = r_width;
        n_pad     = r_pad;
        n_radix   = r_radix;
        n_upper   = r_upper;
        n_prefix  = r_prefix;
        n_sign    = r_sign;
        n_zero    = r_zero;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        cell_op   = itoa_pkg::CELL_HOLD;
        adv       = !r_o_valid || i_ready;
        n_o_valid = r_o_valid && !i_ready;
        o_ready   = 1'b0;

        unique case (r_state)
            itoa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    cell_op  = itoa_pkg::CELL_CLEAR;
                    n_val    = i_value;
                    n_bit    = '0;
                    n_dcnt   = DW'(DIGIT_SLOTS);
                    n_sign   = 1'b0;
                    n_upper  = 1'b0;
                    n_prefix = 1'b0;
                    n_radix  = itoa_pkg::RADIX_DEC;
                    n_zero   = i_pad_zero;
                    n_width  = (w_in > CW'(MAX_FIELD_WIDTH)) ? CW'(MAX_FIELD_WIDTH) : w_in;
                    unique case (i_kind)
                        itoa_pkg::KIND_SDEC: begin
                            if (i_value[VALUE_BITS-1]) begin
                                n_sign = 1'b1;
                                n_val  = ~i_value + VALUE_BITS'(1);
                            end
                        end
                        itoa_pkg::KIND_HEXL: n_radix = itoa_pkg::RADIX_HEX;
                        itoa_pkg::KIND_HEXU: begin
                            n_radix = itoa_pkg::RADIX_HEX;
                            n_upper = 1'b1;
                        end
                        itoa_pkg::KIND_OCT: n_radix = itoa_pkg::RADIX_OCT;
                        itoa_pkg::KIND_PTR: begin
                            n_radix  = itoa_pkg::RADIX_HEX;
                            n_prefix = 1'b1;
                            n_width  = CW'(itoa_pkg::PTR_DIGITS);
                            n_zero   = 1'b1;
                        end
                        default: ;  // unsigned decimal and unused kinds
                    endcase
                    n_state = itoa_pkg::S_CONV;
                end
            end

            // One value bit into the chain per cycle, most significant first
            itoa_pkg::S_CONV: begin
                cell_op = itoa_pkg::CELL_CONV;
                n_val   = {r_val[VALUE_BITS-2:0], 1'b0};
                n_bit   = r_bit + BW'(1);
                if (r_bit == BW'(VALUE_BITS - 1)) begin
                    n_state = itoa_pkg::S_ALIGN;
                end
            end

            // Shift leading zeros out of the top cell; keep at least one digit
            itoa_pkg::S_ALIGN: begin
                if (i_top_digit == 4'd0 && r_dcnt > DW'(1)) begin
                    cell_op = itoa_pkg::CELL_SHIFT;
                    n_dcnt  = r_dcnt - DW'(1);
                end else begin
                    n_state = itoa_pkg::S_SETUP;
                end
            end

            itoa_pkg::S_SETUP: begin
                n_pad = pad_amt;
                if (r_prefix) begin
                    n_state = itoa_pkg::S_PFX0;
                end else if (r_sign && r_zero) begin
                    n_state = itoa_pkg::S_SIGN_LO;
                end else if (pad_amt != '0) begin
                    n_state = itoa_pkg::S_PAD;
                end else if (r_sign) begin
                    n_state = itoa_pkg::S_SIGN_HI;
                end else begin
                    n_state = itoa_pkg::S_DIGITS;
                end
            end

            itoa_pkg::S_PFX0: begin
                if (adv) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::CH_ZERO;
                    n_o_last  = 1'b0;
                    n_state   = itoa_pkg::S_PFX1;
                end
            end

            itoa_pkg::S_PFX1: begin
                if (adv) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::CH_X;
                    n_o_last  = 1'b0;
                    n_state   = (r_pad != '0) ? itoa_pkg::S_PAD : itoa_pkg::S_DIGITS;
                end
            end

            // Minus ahead of zero padding
            itoa_pkg::S_SIGN_LO: begin
                if (adv) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::CH_MINUS;
                    n_o_last  = 1'b0;
                    n_state   = (r_pad != '0) ? itoa_pkg::S_PAD : itoa_pkg::S_DIGITS;
                end
            end

            itoa_pkg::S_PAD: begin
                if (adv) begin
                    n_o_valid = 1'b1;
                    n_o_char  = r_zero ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
                    n_o_last  = 1'b0;
                    n_pad     = r_pad - CW'(1);
                    if (r_pad == CW'(1)) begin
                        n_state = (r_sign && !r_zero) ? itoa_pkg::S_SIGN_HI
                                                      : itoa_pkg::S_DIGITS;
                    end
                end
            end

            // Minus after space padding
            itoa_pkg::S_SIGN_HI: begin
                if (adv) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::CH_MINUS;
                    n_o_last  = 1'b0;
                    n_state   = itoa_pkg::S_DIGITS;
                end
            end

            // Digits leave from the top cell while the chain shifts up
            itoa_pkg::S_DIGITS: begin
                if (adv) begin
                    cell_op   = itoa_pkg::CELL_SHIFT;
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::digit_to_ascii(i_top_digit, r_upper);
                    n_o_last  = (r_dcnt == DW'(1));
                    n_dcnt    = r_dcnt - DW'(1);
                    if (r_dcnt == DW'(1)) begin
                        n_state = itoa_pkg::S_IDLE;
                    end
                end
            end

            default: n_state = itoa_pkg::S_IDLE;
        endcase
    end

    assign o_ctl.op    = cell_op;
    assign o_ctl.radix = r_radix;
    assign o_bit       = r_val[VALUE_BITS-1];
    assign o_valid     = r_o_valid;
    assign o_char      = r_o_char;
    assign o_last      = r_o_last;

endmodule
